/* src/assert_macros.svh */
// assertion macros for the checker file lzssd_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzssd assertion failed: implication");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzssd assertion failed: next cycle");

// next-cycle implication that also covers reset itself
`define ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lzssd assertion failed: after reset");

`endif

/* src/lzssd_pkg.sv */
// constants, codes and beat types of the lzss flag-byte decompressor
// no dependencies
package lzssd_pkg;

   localparam int HIST_DEPTH = 4096;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int IDX_W      = HIST_AW + 1;
   localparam int PROD_W     = $clog2(HIST_DEPTH + 1);
   localparam int MAX_BURST  = 64;
   localparam int BURST_W    = $clog2(MAX_BURST + 1);
   localparam int REM_W      = 24;
   localparam int LEVEL_W    = 5;
   localparam int MAX_LEVEL  = 16;
   localparam int COPY_W     = 17;
   localparam int TOKEN_W    = 16;

   localparam logic [7:0] FLAG_TOP = 8'h80;

   typedef enum logic [2:0] {
      PH_SIZE0 = 3'd0,
      PH_SIZE1 = 3'd1,
      PH_SIZE2 = 3'd2,
      PH_LEVEL = 3'd3,
      PH_FLAG  = 3'd4,
      PH_TOKEN = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       burst_last;
      logic       copy_pending;
      logic       stream_done;
      logic       error;
   } rsp_beat_type;

endpackage

/* src/lzssd_ifs.sv */
// valid/ready channel interfaces for the request and response sides
// no dependencies
interface lzssd_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] in_byte;

   modport source (output valid, output kind, output in_byte, input ready);
   modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

interface lzssd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       burst_last;
   logic       copy_pending;
   logic       stream_done;
   logic       error;

   modport source (output valid, output out_byte, output burst_last, output copy_pending,
                   output stream_done, output error, input ready);
   modport sink   (input valid, input out_byte, input burst_last, input copy_pending,
                   input stream_done, input error, output ready);
endinterface

/* src/lzssd_hist_ram.sv */
// history memory: one write port, one registered read port
// generic, no package dependencies
module lzssd_hist_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/lzssd_out_reg.sv */
// response output register: holds one beat until the sink takes it
// uses lzssd_pkg (beat type) and lzssd_rsp_if
module lzssd_out_reg
   import lzssd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  rsp_beat_type  beat_in,
   output logic          can_load,
   lzssd_rsp_if.source   rsp_ch
);

   logic         valid_ff;
   logic         valid_in;
   rsp_beat_type beat_ff;

   assign can_load = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat_in;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.out_byte     = beat_ff.out_byte;
   assign rsp_ch.burst_last   = beat_ff.burst_last;
   assign rsp_ch.copy_pending = beat_ff.copy_pending;
   assign rsp_ch.stream_done  = beat_ff.stream_done;
   assign rsp_ch.error        = beat_ff.error;

endmodule

/* src/lzss_flag_byte_decompressor_core.sv */
// LZSS flag-byte decompressor. One compressed byte (kind 0) or drain tick (kind 1) is taken per
// request beat while the core is idle; a response beat waiting in the output register does not
// block that. Header bytes, control bytes and the first token byte are taken in idle and give no
// beat. A literal is accepted, then written to history and emitted. A copy byte is a history
// read, then write-back and emit, through the single read port of the history memory; a token
// or drain tick emits up to 64 copy bytes, and the response sink can stall each emit. The
// history memory has no clearing pass.
// uses lzssd_pkg, lzssd_ifs, lzssd_hist_ram, lzssd_out_reg
module lzss_flag_byte_decompressor_core
   import lzssd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lzssd_req_if.sink   req_ch,
   lzssd_rsp_if.source rsp_ch
);

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [HIST_AW-1:0]   wp_ff, wp_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [7:0]           flag_byte_ff, flag_byte_in;
   logic [7:0]           flag_mask_ff, flag_mask_in;
   logic [7:0]           token_high_ff, token_high_in;
   logic [COPY_W-1:0]    copy_left_ff, copy_left_in;
   logic [COPY_W-1:0]    dist_ff, dist_in;
   logic                 err_ff, err_in;
   logic [BURST_W-1:0]   burst_cnt_ff, burst_cnt_in;
   logic                 pend_ff, pend_in;
   logic                 is_lit_ff, is_lit_in;
   logic [7:0]           lit_ff, lit_in;

   logic                 ram_we;
   logic                 ram_re;
   logic [7:0]           ram_wdata;
   logic [HIST_AW-1:0]   ram_raddr;
   logic [7:0]           ram_rdata;

   logic                 out_load;
   logic                 out_can_load;
   rsp_beat_type         beat;

   logic [7:0]           b;
   logic [TOKEN_W-1:0]   tok;
   logic [COPY_W-1:0]    lmask;
   logic [COPY_W-1:0]    len_raw;
   logic [COPY_W-1:0]    len_cap;
   logic [COPY_W-1:0]    dist_new;
   logic [IDX_W-1:0]     idx_sum;
   logic [IDX_W-1:0]     idx_wrap;
   logic                 bad_dist;
   logic [7:0]           emit_val;
   logic                 emit_err;
   logic [REM_W-1:0]     rem_dec;
   logic                 emit_done;
   logic [COPY_W-1:0]    copy_dec;
   logic                 emit_last;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign b            = req_ch.in_byte;

   // token decode from the second token byte
   assign tok      = {token_high_ff, b};
   assign lmask    = (COPY_W'(1) << level_ff) - COPY_W'(1);
   assign len_raw  = COPY_W'(tok & lmask[TOKEN_W-1:0]) + COPY_W'(1);
   assign len_cap  = (REM_W'(len_raw) > rem_ff) ? rem_ff[COPY_W-1:0] : len_raw;
   assign dist_new = COPY_W'(tok >> level_ff) + COPY_W'(1);

   // history read address, wrapped into the window
   assign idx_sum   = IDX_W'(wp_ff) + IDX_W'(HIST_DEPTH) - dist_ff[IDX_W-1:0];
   assign idx_wrap  = (idx_sum >= IDX_W'(HIST_DEPTH)) ? idx_sum - IDX_W'(HIST_DEPTH) : idx_sum;
   assign ram_raddr = idx_wrap[HIST_AW-1:0];

   // emit-side values
   assign bad_dist  = (dist_ff == '0) || (dist_ff > COPY_W'(prod_ff));
   assign emit_val  = is_lit_ff ? lit_ff : (bad_dist ? 8'h00 : ram_rdata);
   assign emit_err  = err_ff || (!is_lit_ff && bad_dist);
   assign rem_dec   = (rem_ff != '0) ? rem_ff - REM_W'(1) : rem_ff;
   assign emit_done = (rem_dec == '0);
   assign copy_dec  = emit_done ? '0 :
                      (is_lit_ff ? copy_left_ff : copy_left_ff - COPY_W'(1));
   assign emit_last = is_lit_ff || (copy_dec == '0) ||
                      (burst_cnt_ff == BURST_W'(MAX_BURST - 1));
   assign ram_wdata = emit_val;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      wp_in         = wp_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      level_in      = level_ff;
      flag_byte_in  = flag_byte_ff;
      flag_mask_in  = flag_mask_ff;
      token_high_in = token_high_ff;
      copy_left_in  = copy_left_ff;
      dist_in       = dist_ff;
      err_in        = err_ff;
      burst_cnt_in  = burst_cnt_ff;
      pend_in       = pend_ff;
      is_lit_in     = is_lit_ff;
      lit_in        = lit_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      out_load      = 1'b0;
      beat          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.kind) begin
                  // drain tick continues a pending copy
                  if (copy_left_ff != '0) begin
                     burst_cnt_in = '0;
                     pend_in      = copy_left_ff > COPY_W'(MAX_BURST);
                     is_lit_in    = 1'b0;
                     state_in     = ST_READ;
                  end
               end else if (copy_left_ff != '0) begin
                  // stream byte while copy pending is dropped
                  err_in = 1'b1;
               end else begin
                  case (phase_ff)
                     PH_SIZE1: begin
                        rem_in   = rem_ff | (REM_W'(b) << 8);
                        phase_in = PH_SIZE2;
                     end
                     PH_SIZE2: begin
                        rem_in   = rem_ff | (REM_W'(b) << 16);
                        phase_in = PH_LEVEL;
                     end
                     PH_LEVEL: begin
                        level_in     = (b > 8'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL)
                                                           : b[LEVEL_W-1:0];
                        prod_in      = '0;
                        flag_byte_in = '0;
                        flag_mask_in = '0;
                        phase_in     = (rem_ff != '0) ? PH_FLAG : PH_SIZE0;
                     end
                     PH_FLAG: begin
                        if (flag_mask_ff == '0) begin
                           flag_byte_in = b;
                           flag_mask_in = FLAG_TOP;
                        end else if ((flag_byte_ff & flag_mask_ff) != '0) begin
                           token_high_in = b;
                           phase_in      = PH_TOKEN;
                        end else begin
                           flag_mask_in = flag_mask_ff >> 1;
                           lit_in       = b;
                           is_lit_in    = 1'b1;
                           state_in     = ST_EMIT;
                        end
                     end
                     PH_TOKEN: begin
                        dist_in      = dist_new;
                        copy_left_in = len_cap;
                        flag_mask_in = flag_mask_ff >> 1;
                        phase_in     = PH_FLAG;
                        burst_cnt_in = '0;
                        pend_in      = len_cap > COPY_W'(MAX_BURST);
                        is_lit_in    = 1'b0;
                        state_in     = ST_READ;
                     end
                     default: begin
                        rem_in   = REM_W'(b);
                        err_in   = 1'b0;
                        phase_in = PH_SIZE1;
                     end
                  endcase
               end
            end
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_can_load) begin
               ram_we            = 1'b1;
               out_load          = 1'b1;
               beat.out_byte     = emit_val;
               beat.burst_last   = emit_last;
               beat.copy_pending = !is_lit_ff && pend_ff;
               beat.stream_done  = emit_done;
               beat.error        = emit_err;
               err_in            = emit_err;
               rem_in            = rem_dec;
               copy_left_in      = copy_dec;
               wp_in             = (wp_ff == HIST_AW'(HIST_DEPTH - 1)) ? '0
                                                                      : wp_ff + HIST_AW'(1);
               if (prod_ff < PROD_W'(HIST_DEPTH)) begin
                  prod_in = prod_ff + PROD_W'(1);
               end
               if (emit_done) begin
                  phase_in = PH_SIZE0;
               end
               burst_cnt_in = burst_cnt_ff + BURST_W'(1);
               state_in     = emit_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_SIZE0;
         wp_ff         <= '0;
         prod_ff       <= '0;
         rem_ff        <= '0;
         level_ff      <= '0;
         flag_byte_ff  <= '0;
         flag_mask_ff  <= '0;
         token_high_ff <= '0;
         copy_left_ff  <= '0;
         dist_ff       <= '0;
         err_ff        <= 1'b0;
         burst_cnt_ff  <= '0;
         pend_ff       <= 1'b0;
         is_lit_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         wp_ff         <= wp_in;
         prod_ff       <= prod_in;
         rem_ff        <= rem_in;
         level_ff      <= level_in;
         flag_byte_ff  <= flag_byte_in;
         flag_mask_ff  <= flag_mask_in;
         token_high_ff <= token_high_in;
         copy_left_ff  <= copy_left_in;
         dist_ff       <= dist_in;
         err_ff        <= err_in;
         burst_cnt_ff  <= burst_cnt_in;
         pend_ff       <= pend_in;
         is_lit_ff     <= is_lit_in;
      end
   end

   always_ff @(posedge clock) begin
      lit_ff <= lit_in;
   end

   lzssd_hist_ram #(
      .DEPTH (HIST_DEPTH),
      .WIDTH (8)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   lzssd_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (out_load),
      .beat_in  (beat),
      .can_load (out_can_load),
      .rsp_ch   (rsp_ch)
   );

endmodule

/* src/lzssd_checker.sv */
// port-level checks of the decompressor core and the bind that attaches them
// uses assert_macros.svh; binds to lzss_flag_byte_decompressor_core
`include "assert_macros.svh"

module lzssd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       burst_last,
   input logic       copy_pending,
   input logic       stream_done,
   input logic       error
);

   // a stalled beat holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_byte) && $stable(burst_last) && $stable(copy_pending) && $stable(stream_done) && $stable(error))

   // end of stream always closes the burst
   `ASSERT_IMPLY(a_done_is_last, clock, reset, rsp_valid && stream_done, burst_last)

   // a copy that outlives the burst cannot finish the stream
   `ASSERT_IMPLY(a_pend_not_done, clock, reset, rsp_valid && copy_pending, !stream_done)

   // mid-burst the core is busy and takes no request beat
   `ASSERT_IMPLY(a_busy_mid_burst, clock, reset, rsp_valid && !burst_last, !req_ready)

   `ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind lzss_flag_byte_decompressor_core lzssd_checker u_lzssd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .out_byte     (rsp_ch.out_byte),
   .burst_last   (rsp_ch.burst_last),
   .copy_pending (rsp_ch.copy_pending),
   .stream_done  (rsp_ch.stream_done),
   .error        (rsp_ch.error)
);

/* tb/sv/lzssd_stream_checker.sv */
`timescale 1ns / 100ps
// scoreboard for the lzss flag-byte decompressor: decodes every accepted request beat into
// the response beats it must cause and compares them, in order, with what the core returns
// depends on lzssd_pkg and the channel interfaces in lzssd_ifs
module lzssd_stream_checker
   import lzssd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lzssd_req_if        req_mon,
   lzssd_rsp_if        rsp_mon,
   output int unsigned fail_count,
   output int unsigned outstanding
);

   logic [7:0]         hist_mem [HIST_DEPTH];
   logic [HIST_AW-1:0] wr_ptr;
   logic [PROD_W-1:0]  produced;
   phase_type          phase;
   logic [REM_W-1:0]   remaining;
   logic [LEVEL_W-1:0] level;
   logic [7:0]         ctl_byte;
   logic [7:0]         ctl_mask;
   logic [7:0]         tok_hi;
   logic [COPY_W-1:0]  copy_left;
   logic [COPY_W-1:0]  copy_dist;
   logic               err_flag;

   rsp_beat_type item_bytes[$];
   rsp_beat_type expected_bytes[$];

   function void emit_byte(logic [7:0] v);
      rsp_beat_type rb;
      hist_mem[wr_ptr] = v;
      wr_ptr = (int'(wr_ptr) == HIST_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      if (produced < HIST_DEPTH) begin
         produced = produced + 1'b1;
      end
      if (remaining != 0) begin
         remaining = remaining - 1'b1;
      end
      rb.out_byte     = v;
      rb.burst_last   = 1'b0;
      rb.copy_pending = 1'b0;
      rb.stream_done  = (remaining == 0);
      rb.error        = err_flag;
      if (remaining == 0) begin
         phase     = PH_SIZE0;
         copy_left = '0;
      end
      item_bytes.push_back(rb);
   endfunction

   function void copy_burst();
      int         n;
      int         idx;
      logic [7:0] v;
      n = 0;
      while (copy_left != 0 && n < MAX_BURST) begin
         v = 8'h00;
         // distance beyond what this stream has produced reads as zero and flags an error
         if (copy_dist == 0 || copy_dist > produced) begin
            err_flag = 1'b1;
         end else begin
            idx = int'(wr_ptr) + HIST_DEPTH - int'(copy_dist);
            if (idx >= HIST_DEPTH) begin
               idx -= HIST_DEPTH;
            end
            v = hist_mem[idx];
         end
         copy_left = copy_left - 1'b1;
         emit_byte(v);
         n++;
      end
   endfunction

   function void decode_beat(logic is_drain, logic [7:0] b);
      logic [TOKEN_W-1:0] tok;
      logic [COPY_W-1:0]  len_mask;
      logic [COPY_W-1:0]  span;
      item_bytes.delete();
      if (is_drain) begin
         copy_burst();
      end else if (copy_left != 0) begin
         // stream byte during a pending copy is dropped
         err_flag = 1'b1;
      end else begin
         case (phase)
            PH_SIZE1: begin
               remaining[15:8] = b;
               phase = PH_SIZE2;
            end
            PH_SIZE2: begin
               remaining[23:16] = b;
               phase = PH_LEVEL;
            end
            PH_LEVEL: begin
               level    = (b > MAX_LEVEL) ? LEVEL_W'(MAX_LEVEL) : b[LEVEL_W-1:0];
               produced = '0;
               ctl_byte = 8'h00;
               ctl_mask = 8'h00;
               phase    = (remaining != 0) ? PH_FLAG : PH_SIZE0;
            end
            PH_FLAG: begin
               if (ctl_mask == 0) begin
                  ctl_byte = b;
                  ctl_mask = FLAG_TOP;
               end else if ((ctl_byte & ctl_mask) != 0) begin
                  tok_hi = b;
                  phase  = PH_TOKEN;
               end else begin
                  ctl_mask = ctl_mask >> 1;
                  emit_byte(b);
               end
            end
            PH_TOKEN: begin
               tok      = {tok_hi, b};
               len_mask = (COPY_W'(1) << level) - 1'b1;
               span     = ({1'b0, tok} & len_mask) + 1'b1;
               if (span > remaining) begin
                  span = COPY_W'(remaining);
               end
               copy_dist = ({1'b0, tok} >> level) + 1'b1;
               copy_left = span;
               ctl_mask  = ctl_mask >> 1;
               phase     = PH_FLAG;
               copy_burst();
            end
            default: begin
               remaining = {16'h0000, b};
               err_flag  = 1'b0;
               phase     = PH_SIZE1;
            end
         endcase
      end
      foreach (item_bytes[i]) begin
         item_bytes[i].copy_pending = (copy_left != 0);
      end
      if (item_bytes.size() != 0) begin
         item_bytes[item_bytes.size() - 1].burst_last = 1'b1;
      end
      foreach (item_bytes[i]) begin
         expected_bytes.push_back(item_bytes[i]);
      end
   endfunction

   function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_mem[i] = 8'h00;
         end
         wr_ptr    = '0;
         produced  = '0;
         phase     = PH_SIZE0;
         remaining = '0;
         level     = '0;
         ctl_byte  = 8'h00;
         ctl_mask  = 8'h00;
         tok_hi    = 8'h00;
         copy_left = '0;
         copy_dist = '0;
         err_flag  = 1'b0;
         expected_bytes.delete();
      end else begin
         // a response beat never stems from the request beat taken at the same edge
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got = {rsp_mon.out_byte, rsp_mon.burst_last, rsp_mon.copy_pending,
                   rsp_mon.stream_done, rsp_mon.error};
            if (expected_bytes.size() == 0) begin
               $error("response beat with nothing expected: out_byte %0h", got.out_byte);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               check_field("out_byte", want.out_byte, got.out_byte);
               check_field("burst_last", want.burst_last, got.burst_last);
               check_field("copy_pending", want.copy_pending, got.copy_pending);
               check_field("stream_done", want.stream_done, got.stream_done);
               check_field("error", want.error, got.error);
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            decode_beat(req_mon.kind, req_mon.in_byte);
         end
      end
      outstanding = expected_bytes.size();
   end

endmodule

/* tb/sv/lzss_flag_byte_decompressor_core_test.sv */
`timescale 1ns / 100ps
// top of the decompressor test: builds compressed streams, drives them with random idling
// on both channels and gives the verdict from the scoreboard's failure count
// depends on lzssd_pkg, lzssd_ifs, lzssd_stream_checker and the core
module lzss_flag_byte_decompressor_core_test;
   import lzssd_pkg::*;

   localparam logic        KIND_BYTE    = 1'b0;
   localparam logic        KIND_DRAIN   = 1'b1;
   localparam int unsigned RANDOM_BEATS = 390;
   localparam int unsigned REQ_GAP_MAX  = 30;
   localparam int unsigned RSP_GAP_MAX  = 40;
   localparam int unsigned HOLD_AT      = 60;
   localparam int unsigned HOLD_CYCLES  = 600;
   localparam int unsigned END_CYCLES   = 300;

   typedef struct {
      logic       kind;
      logic [7:0] data;
      bit         wait_drain;
   } coded_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lzssd_req_if req_ch ();
   lzssd_rsp_if rsp_ch ();

   int unsigned fail_count;
   int unsigned outstanding;

   coded_beat_type  coded_beats[$];
   int unsigned     counted_beats = 0;
   int unsigned     sent_count = 0;
   longint unsigned cycle_limit = 0;
   longint unsigned cycle_count = 0;
   bit              req_steady = 1'b0;
   bit              rsp_steady = 1'b0;

   lzss_flag_byte_decompressor_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   lzssd_stream_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned idle_gap(ref bit steady, input int unsigned longest);
      int unsigned pick;
      if ($urandom_range(0, 99) < 3) begin
         steady = !steady;
      end
      if (steady) begin
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 0;
      end
      if (pick < 90) begin
         return $urandom_range(1, 3);
      end
      if (pick < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(longest / 2, longest);
   endfunction

   function automatic void push_beat(logic kind, logic [7:0] data, bit counts = 1'b1);
      coded_beat_type cb;
      cb.kind       = kind;
      cb.data       = data;
      cb.wait_drain = 1'b0;
      coded_beats.push_back(cb);
      if (counts) begin
         counted_beats++;
      end
   endfunction

   function automatic void push_header(logic [23:0] size, logic [7:0] lvl_byte);
      push_beat(KIND_BYTE, size[7:0]);
      push_beat(KIND_BYTE, size[15:8]);
      push_beat(KIND_BYTE, size[23:16]);
      push_beat(KIND_BYTE, lvl_byte);
   endfunction

   // one complete stream: header, then control bytes each followed by its literals and
   // tokens, with drain ticks after long copies and a little noise in between
   function automatic void build_stream(int unsigned size, logic [7:0] lvl_byte,
                                        bit long_copies);
      int unsigned left, avail, lvl, max_len, max_back, len, back, take, tok, pick, ctl_at;
      logic [7:0]  ctl;
      push_header(24'(size), lvl_byte);
      lvl      = (lvl_byte > MAX_LEVEL) ? MAX_LEVEL : lvl_byte;
      max_len  = 1 << lvl;
      max_back = 1 << (16 - lvl);
      left     = size;
      avail    = 0;
      while (left != 0) begin
         ctl    = 8'($urandom);
         ctl_at = coded_beats.size();
         push_beat(KIND_BYTE, 8'h00);
         for (int bitpos = 7; bitpos >= 0 && left != 0; bitpos--) begin
            // drain tick with nothing pending
            if ($urandom_range(0, 99) < 3) begin
               push_beat(KIND_DRAIN, 8'($urandom), 1'b0);
            end
            if ($urandom_range(0, 99) < 45) begin
               ctl[bitpos] = 1'b0;
               push_beat(KIND_BYTE, 8'($urandom));
               take = 1;
            end else begin
               ctl[bitpos] = 1'b1;
               pick = $urandom_range(0, 99);
               if (long_copies && pick < 50) begin
                  len = $urandom_range(1, max_len);
               end else if (pick < 70) begin
                  len = $urandom_range(1, (max_len < 8) ? max_len : 8);
               end else if (pick < 95) begin
                  len = $urandom_range(1, (max_len < 130) ? max_len : 130);
               end else begin
                  len = $urandom_range(1, max_len);
               end
               if (avail != 0 && $urandom_range(0, 99) < 88) begin
                  back = $urandom_range(1, (avail < max_back) ? avail : max_back);
               end else if (avail < max_back) begin
                  back = $urandom_range(avail + 1, max_back);
               end else begin
                  back = $urandom_range(1, max_back);
               end
               tok = ((back - 1) << lvl) | (len - 1);
               push_beat(KIND_BYTE, tok[15:8]);
               push_beat(KIND_BYTE, tok[7:0]);
               take = (len < left) ? len : left;
               // stray stream byte while the copy is still pending
               if (take > MAX_BURST && $urandom_range(0, 99) < 20) begin
                  push_beat(KIND_BYTE, 8'($urandom), 1'b0);
               end
               for (int d = 1; d < (take + MAX_BURST - 1) / MAX_BURST; d++) begin
                  push_beat(KIND_DRAIN, 8'($urandom));
               end
            end
            left -= take;
            avail = (avail + take > HIST_DEPTH) ? HIST_DEPTH : avail + take;
         end
         coded_beats[ctl_at].data = ctl;
      end
   endfunction

   function automatic void build_directed();
      // empty stream ends right after its level byte
      push_header(24'h000000, 8'h07);
      // level above the clamp; first token reaches back before the stream start
      push_header(24'h000046, 8'h14);
      push_beat(KIND_BYTE, 8'hA0);
      push_beat(KIND_BYTE, 8'h00);
      push_beat(KIND_BYTE, 8'h00);
      push_beat(KIND_BYTE, 8'hFF);
      // 68-byte copy: one full burst, a dropped byte, then a drain finishes the stream
      push_beat(KIND_BYTE, 8'h00);
      push_beat(KIND_BYTE, 8'h43);
      push_beat(KIND_BYTE, 8'h5A);
      push_beat(KIND_DRAIN, 8'hA5);
      push_beat(KIND_DRAIN, 8'hFF);
      // next header clears the error; short copy at distance two
      push_header(24'h000003, 8'h04);
      push_beat(KIND_BYTE, 8'h20);
      push_beat(KIND_BYTE, 8'h00);
      push_beat(KIND_BYTE, 8'h80);
      push_beat(KIND_BYTE, 8'h00);
      push_beat(KIND_BYTE, 8'h10);
   endfunction

   function automatic void build_random();
      int unsigned first, size, pick, target;
      logic [7:0]  lvl_byte;
      first  = coded_beats.size();
      target = counted_beats + RANDOM_BEATS;
      // one stream past the window size, wrapping history and saturating the count
      build_stream($urandom_range(4200, 4800), 8'd12, 1'b1);
      coded_beats[first].wait_drain = 1'b1;
      while (counted_beats < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            size = 0;
         end else if (pick < 75) begin
            size = $urandom_range(1, 40);
         end else begin
            size = $urandom_range(41, 400);
         end
         if ($urandom_range(0, 99) < 10) begin
            lvl_byte = 8'($urandom_range(17, 255));
         end else begin
            lvl_byte = 8'($urandom_range(0, 16));
         end
         build_stream(size, lvl_byte, 1'b0);
      end
      // largest declared size, left open at the end of the run
      push_header(24'hFFFFFF, 8'($urandom_range(0, 16)));
      push_beat(KIND_BYTE, 8'h00);
      for (int i = 0; i < 3; i++) begin
         push_beat(KIND_BYTE, 8'($urandom));
      end
   endfunction

   initial begin
      int unsigned gap;
      req_ch.valid   = 1'b0;
      req_ch.kind    = KIND_BYTE;
      req_ch.in_byte = 8'h00;
      build_directed();
      build_random();
      cycle_limit = 4 * (longint'(coded_beats.size()) *
                         (REQ_GAP_MAX + 2 + MAX_BURST * (RSP_GAP_MAX + 3))
                         + HOLD_CYCLES + END_CYCLES) + 1000;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (coded_beats[i]) begin
         gap = idle_gap(req_steady, REQ_GAP_MAX);
         if (coded_beats[i].wait_drain || gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat ((gap > 0) ? gap : 1) @(negedge clock);
            if (coded_beats[i].wait_drain) begin
               while (outstanding != 0) @(negedge clock);
            end
         end
         req_ch.valid   <= 1'b1;
         req_ch.kind    <= coded_beats[i].kind;
         req_ch.in_byte <= coded_beats[i].data;
         @(posedge clock);
         while (req_ch.ready !== 1'b1) @(posedge clock);
         sent_count++;
         @(negedge clock);
      end
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (END_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // response side: random stalls after beats, plus one long hold-off that backs up the core
   initial begin
      int unsigned stall;
      bit          hold_done;
      rsp_ch.ready = 1'b0;
      stall        = 0;
      hold_done    = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && sent_count >= HOLD_AT) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            stall = idle_gap(rsp_steady, RSP_GAP_MAX);
         end
      end
   end

   initial begin
      wait (cycle_limit != 0);
      while (cycle_count < cycle_limit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

endmodule
